FILE: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication checked on every rising clock edge, off while reset is high
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/hnpm_pkg.sv
package hnpm_pkg;

   // dictionary size and derived widths
   localparam int DICT_DEPTH = 16;
   localparam int CELL_IDX_W = $clog2(DICT_DEPTH);
   localparam int WORD_W     = 64;
   localparam int DIST_W     = 7;
   localparam int SLOT_W     = 4;
   localparam int CFG_W      = 5;
   localparam int CMP_W      = (SLOT_W > CELL_IDX_W) ? SLOT_W : CELL_IDX_W;
   localparam int ACT_W      = (CFG_W > CELL_IDX_W + 1) ? CFG_W : CELL_IDX_W + 1;

   // running best before any entry is compared
   localparam logic [DIST_W-1:0] NO_MATCH_DISTANCE = DIST_W'(65);

   // item commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_MATCH = 1'b1;

   // payload of an item as it walks the chain
   typedef struct packed {
      logic                  cmd;
      logic [SLOT_W-1:0]     slot;
      logic [WORD_W-1:0]     word;
      logic [CELL_IDX_W-1:0] best_idx;
      logic [DIST_W-1:0]     best_dist;
   } tok_pay_type;

   typedef struct packed {
      logic        valid;
      tok_pay_type pay;
   } tok_type;

   // number of set bits in a word
   function automatic logic [DIST_W-1:0] count_ones(input logic [WORD_W-1:0] w);
      logic [DIST_W-1:0] part [WORD_W];
      for (int k = 0; k < WORD_W; k++) begin
         part[k] = DIST_W'(w[k]);
      end
      // pairwise adder tree, log2 of the word width levels deep
      for (int span = 1; span < WORD_W; span = span * 2) begin
         for (int k = 0; k < WORD_W; k = k + 2 * span) begin
            part[k] = part[k] + part[k + span];
         end
      end
      return part[0];
   endfunction

endpackage

FILE: rtl/core/hnpm_ifs.sv
// request channel: load or match item
interface hnpm_req_if import hnpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [SLOT_W-1:0] entry_index;
   logic [WORD_W-1:0] bit_word;

   modport source (output valid, cmd, entry_index, bit_word, input ready);
   modport sink   (input valid, cmd, entry_index, bit_word, output ready);
endinterface

// response channel: nearest entry of a match item
interface hnpm_rsp_if import hnpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] best_index;
   logic [DIST_W-1:0] best_distance;

   modport source (output valid, best_index, best_distance, input ready);
   modport sink   (input valid, best_index, best_distance, output ready);
endinterface

// register write channel: entries_in_use
interface hnpm_csr_if import hnpm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/hnpm_cell.sv
module hnpm_cell import hnpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  active,
   input  logic [CELL_IDX_W-1:0] cell_index,
   input  tok_type               tok_in,
   output tok_type               tok_out
);

   logic [WORD_W-1:0] pat_ff;
   logic              valid_ff;
   tok_pay_type       pay_ff;
   tok_pay_type       pay_in;
   logic [DIST_W-1:0] entry_dist;
   logic              take;
   logic              write;

   // distance of the passing tile to this entry
   assign entry_dist = count_ones(tok_in.pay.word ^ pat_ff);

   // strictly closer wins, so the lower index keeps a tie
   assign take = tok_in.valid && (tok_in.pay.cmd == CMD_MATCH) && active &&
                 (entry_dist < tok_in.pay.best_dist);

   assign write = tok_in.valid && (tok_in.pay.cmd == CMD_LOAD) &&
                  (CMP_W'(tok_in.pay.slot) == CMP_W'(cell_index));

   // update running best
   always_comb begin
      pay_in = tok_in.pay;
      if (take) begin
         pay_in.best_idx  = cell_index;
         pay_in.best_dist = entry_dist;
      end
   end

   // item valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= tok_in.valid;
      end
   end

   // item payload and stored entry
   always_ff @(posedge clock) begin
      if (advance) begin
         pay_ff <= pay_in;
         if (write) begin
            pat_ff <= tok_in.pay.word;
         end
      end
   end

   assign tok_out = '{valid: valid_ff, pay: pay_ff};

endmodule

FILE: rtl/core/hnpm_chain.sv
module hnpm_chain import hnpm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [CFG_W-1:0] entries_in_use,
   input  tok_type          head,
   output tok_type          tail
);

   tok_type link [DICT_DEPTH+1];

   assign link[0] = head;

   // one cell per dictionary entry, items hop one cell per advance
   for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
      logic active;

      // entry zero is always searched; a count past the depth searches all
      assign active = (i == 0) || (ACT_W'(entries_in_use) > ACT_W'(i));

      hnpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .active     (active),
         .cell_index (CELL_IDX_W'(i)),
         .tok_in     (link[i]),
         .tok_out    (link[i+1])
      );
   end

   assign tail = link[DICT_DEPTH];

endmodule

FILE: rtl/core/hamming_nearest_pattern_match.sv
// Nearest-pattern search by Hamming distance. A load item (cmd 0) stores bit_word as
// dictionary entry entry_index; a match item (cmd 1) returns the index and distance of
// the closest of the first entries_in_use entries, lowest index on a tie. Every item
// walks a chain of DICT_DEPTH cells (16), one cell per entry, one hop per cycle, so the
// block takes one item per cycle while the response is not stalled; a match result shows
// on the response port from the register of the last cell and is taken at the next edge
// at the earliest; loads and matches stay in order. A stalled response stalls the
// whole chain. Entries must be loaded before a match searches them.
module hamming_nearest_pattern_match import hnpm_pkg::*; (
   input logic      clock,
   input logic      reset,
   hnpm_req_if.sink   req_ch,
   hnpm_rsp_if.source rsp_ch,
   hnpm_csr_if.sink   csr_ch
);

   logic [CFG_W-1:0] used_ff;
   logic             advance;
   tok_type          head;
   tok_type          tail;

   // entries_in_use register
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= CFG_W'(16);
      end else if (csr_ch.valid) begin
         used_ff <= csr_ch.data;
      end
   end

   // chain moves unless a finished result waits
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // new item enters with no best yet
   always_comb begin
      head.valid         = req_ch.valid;
      head.pay.cmd       = req_ch.cmd;
      head.pay.slot      = req_ch.entry_index;
      head.pay.word      = req_ch.bit_word;
      head.pay.best_idx  = '0;
      head.pay.best_dist = NO_MATCH_DISTANCE;
   end

   hnpm_chain u_chain (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .entries_in_use (used_ff),
      .head           (head),
      .tail           (tail)
   );

   // last cell register is the response register; loads drop out here
   assign rsp_ch.valid         = tail.valid && (tail.pay.cmd == CMD_MATCH);
   assign rsp_ch.best_index    = SLOT_W'(tail.pay.best_idx);
   assign rsp_ch.best_distance = tail.pay.best_dist;

endmodule

FILE: rtl/core/hnpm_checker.sv
`include "assert_macros.svh"

module hnpm_checker import hnpm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [SLOT_W-1:0] best_index,
   input logic [DIST_W-1:0] best_distance
);

   logic                     rsp_stall;
   logic [SLOT_W+DIST_W-1:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {best_index, best_distance};

   // a stalled response keeps its item
   `ASSERT_CLK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "result moved in stall")

   // input is held off only behind a stalled response
   `ASSERT_IMPL(a_req_stall, !req_ready, rsp_stall, "input stalled without cause")

   // a result distance never exceeds the word width
   `ASSERT_IMPL(a_dist_range, rsp_valid, best_distance <= DIST_W'(WORD_W), "distance out of range")

   // an item offered while the response drains is taken
   `ASSERT_IMPL(a_req_take, req_valid && rsp_ready, req_ready, "item refused while output free")

endmodule

bind hamming_nearest_pattern_match hnpm_checker u_hnpm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .best_index    (rsp_ch.best_index),
   .best_distance (rsp_ch.best_distance)
);
